// ===== rtl/tst_pkg.sv =====
// Shared types, codes and sizes for the topic subscription table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

    // Default table geometry and the largest supported table
    localparam int TOPICS_DEF = 10;
    localparam int SLOTS_DEF  = 5;
    localparam int TOPICS_MAX = 64;
    localparam int USED_W     = $clog2(TOPICS_MAX + 1);

    // Field widths
    localparam int KEY_W     = 64;
    localparam int CLIENT_W  = 10;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 3;
    localparam int IN_DATA_W = 144;
    localparam int OUT_DATA_W = 16;
    localparam int QDEPTH    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SUB   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNSUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PUB   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] K_SUBACK      = 3'd0;
    localparam logic [KIND_W-1:0] K_UNSUBACK    = 3'd1;
    localparam logic [KIND_W-1:0] K_DELIVER     = 3'd2;
    localparam logic [KIND_W-1:0] K_SLOTS_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] K_TOPICS_FULL = 3'd4;
    localparam logic [KIND_W-1:0] K_NOT_FOUND   = 3'd5;

    // One classified request
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    hi;
        logic [KEY_W-1:0]    lo;
        logic [CLIENT_W-1:0] client;
    } t_req;

endpackage

`default_nettype wire

// ===== rtl/tst_front.sv =====
// Front end: accepts stream items, drops no-op commands, holds one request.
// Depends on tst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tst_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [tst_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  wire  [tst_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                             o_req_valid,
    input  wire                              i_req_ready,
    output tst_pkg::t_req                    o_req
);

    logic          r_vld;
    tst_pkg::t_req r_req;
    logic          w_take;

    // Take a new item whenever the holding register is empty or draining
    assign o_s_tready = !r_vld || i_req_ready;
    assign w_take     = i_s_tvalid && o_s_tready;

    // Hold valid only for commands other than no-op; drop no-ops on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid && (i_s_tuser != tst_pkg::CMD_NOP);
        end
    end

    // Unpack payload: key high, key low, client from the lowest bit up
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req.cmd    <= i_s_tuser;
            r_req.hi     <= i_s_tdata[tst_pkg::KEY_W-1:0];
            r_req.lo     <= i_s_tdata[2*tst_pkg::KEY_W-1:tst_pkg::KEY_W];
            r_req.client <= i_s_tdata[2*tst_pkg::KEY_W+tst_pkg::CLIENT_W-1:2*tst_pkg::KEY_W];
        end
    end

    assign o_req_valid = r_vld;
    assign o_req       = r_req;

endmodule

`default_nettype wire

// ===== rtl/tst_queue.sv =====
// Short request queue between the front end and the table engine.
// Depends on tst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tst_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_wr_valid,
    output logic           o_wr_ready,
    input  tst_pkg::t_req  i_wr_data,
    output logic           o_rd_valid,
    input  wire            i_rd_ready,
    output tst_pkg::t_req  o_rd_data
);

    localparam int QAW = $clog2(tst_pkg::QDEPTH);
    localparam int QCW = $clog2(tst_pkg::QDEPTH + 1);

    tst_pkg::t_req  r_mem [tst_pkg::QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_wr_ready = (r_cnt != QCW'(tst_pkg::QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(tst_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(tst_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tst_back.sv =====
// Table engine: topic key scan, slot scans, table updates and result output.
// Holds the key, topic row and slot client memories. Depends on tst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tst_back #(
    parameter int TOPICS = tst_pkg::TOPICS_DEF,
    parameter int SLOTS  = tst_pkg::SLOTS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_req_valid,
    output logic                             o_req_ready,
    input  tst_pkg::t_req                    i_req,
    output logic                             o_m_valid,
    input  wire                              i_m_ready,
    output logic [tst_pkg::KIND_W-1:0]       o_m_kind,
    output logic [tst_pkg::CLIENT_W-1:0]     o_m_dest,
    output logic                             o_m_last,
    output logic [tst_pkg::USED_W-1:0]       o_used_cnt
);

    localparam int TIW   = $clog2(TOPICS);
    localparam int TCW   = $clog2(TOPICS + 1);
    localparam int SCW   = $clog2(SLOTS + 1);
    localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NCELL = TOPICS * SLOTS;
    localparam int AW    = $clog2(NCELL);
    localparam int BW    = $clog2(NCELL + 1);
    localparam int RW    = SCW + SLOTS;
    localparam int KW    = 2 * tst_pkg::KEY_W;
    localparam int CW    = tst_pkg::CLIENT_W;

    // Engine states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KRD   = 4'd1;
    localparam logic [3:0] S_KCMP  = 4'd2;
    localparam logic [3:0] S_HIT   = 4'd3;
    localparam logic [3:0] S_MISS  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SCMP  = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DEMIT = 4'd8;

    // Memories: key per topic, {next slot, valid mask} per topic, client per slot
    logic [KW-1:0] m_key [TOPICS];
    logic [RW-1:0] m_row [TOPICS];
    logic [CW-1:0] m_cli [NCELL];

    logic [KW-1:0] r_key_q;
    logic [RW-1:0] r_row_q;
    logic [CW-1:0] r_cli_q;

    logic [3:0]    r_state, n_state;
    tst_pkg::t_req r_req;
    logic [TCW-1:0] r_t, n_t;
    logic [BW-1:0]  r_base, n_base;
    logic [TCW-1:0] r_used, n_used;
    logic [SCW-1:0] r_s, n_s;
    logic [SLOTS-1:0] r_mask, n_mask;
    logic [SCW-1:0] r_next, n_next;

    logic                       r_out_vld;
    logic [tst_pkg::KIND_W-1:0] r_out_kind;
    logic [CW-1:0]              r_out_dest;
    logic                       r_out_last;

    logic                       w_out_free;
    logic                       w_emit;
    logic [tst_pkg::KIND_W-1:0] w_e_kind;
    logic [CW-1:0]              w_e_dest;
    logic                       w_e_last;

    logic          w_key_re, w_row_re, w_cli_re;
    logic          w_key_we, w_row_we, w_cli_we;
    logic [RW-1:0] w_row_wdata;
    logic [SCW-1:0] w_cli_woff;
    logic [BW-1:0] w_rd_sum;
    logic [BW-1:0] w_wr_sum;
    logic [SLOTS-1:0] w_bit_next;
    logic [SLOTS-1:0] w_bit_s;
    logic [SLOTS-1:0] w_above;
    logic          w_final;
    logic          w_take;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_take      = i_req_valid && o_req_ready;
    assign w_out_free  = !r_out_vld || i_m_ready;

    assign w_rd_sum   = r_base + BW'(r_s);
    assign w_wr_sum   = r_base + BW'(w_cli_woff);
    assign w_bit_next = SLOTS'(1) << r_next;
    assign w_bit_s    = SLOTS'(1) << r_s;
    assign w_above    = r_mask >> r_s;
    assign w_final    = ((w_above >> 1) == '0);

    // Sequence one request through scan, update and result
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_base      = r_base;
        n_used      = r_used;
        n_s         = r_s;
        n_mask      = r_mask;
        n_next      = r_next;
        w_key_re    = 1'b0;
        w_row_re    = 1'b0;
        w_cli_re    = 1'b0;
        w_key_we    = 1'b0;
        w_row_we    = 1'b0;
        w_cli_we    = 1'b0;
        w_row_wdata = '0;
        w_cli_woff  = '0;
        w_emit      = 1'b0;
        w_e_kind    = tst_pkg::K_NOT_FOUND;
        w_e_dest    = r_req.client;
        w_e_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_t     = '0;
                    n_base  = '0;
                    n_state = S_KRD;
                end
            end
            // Read the next allocated topic, or stop at the fill count
            S_KRD: begin
                if (r_t == r_used) begin
                    n_state = S_MISS;
                end else begin
                    w_key_re = 1'b1;
                    w_row_re = 1'b1;
                    n_state  = S_KCMP;
                end
            end
            S_KCMP: begin
                if (r_key_q == {r_req.hi, r_req.lo}) begin
                    n_next  = r_row_q[RW-1:SLOTS];
                    n_mask  = r_row_q[SLOTS-1:0];
                    n_state = S_HIT;
                end else begin
                    n_t     = r_t + 1'b1;
                    n_base  = r_base + BW'(SLOTS);
                    n_state = S_KRD;
                end
            end
            // Topic found
            S_HIT: begin
                if (r_req.cmd == tst_pkg::CMD_SUB) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                        if (r_next >= SCW'(SLOTS)) begin
                            w_e_kind = tst_pkg::K_SLOTS_FULL;
                        end else begin
                            w_e_kind    = tst_pkg::K_SUBACK;
                            w_cli_we    = 1'b1;
                            w_cli_woff  = r_next;
                            w_row_we    = 1'b1;
                            w_row_wdata = {r_next + 1'b1, r_mask | w_bit_next};
                        end
                    end
                end else begin
                    n_s     = '0;
                    n_state = S_SRD;
                end
            end
            // No topic with this key
            S_MISS: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_req.cmd == tst_pkg::CMD_SUB) begin
                        if (r_used == TCW'(TOPICS)) begin
                            w_e_kind = tst_pkg::K_TOPICS_FULL;
                        end else begin
                            w_e_kind    = tst_pkg::K_SUBACK;
                            w_key_we    = 1'b1;
                            w_row_we    = 1'b1;
                            w_row_wdata = {SCW'(1), SLOTS'(1)};
                            w_cli_we    = 1'b1;
                            n_used      = r_used + 1'b1;
                        end
                    end
                end
            end
            // Look for the requester among the valid slots
            S_SRD: begin
                if (r_s == SCW'(SLOTS)) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (!r_mask[r_s[SIW-1:0]]) begin
                    n_s = r_s + 1'b1;
                end else begin
                    w_cli_re = 1'b1;
                    n_state  = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_cli_q == r_req.client) begin
                    if (r_req.cmd == tst_pkg::CMD_UNSUB) begin
                        if (w_out_free) begin
                            w_emit      = 1'b1;
                            w_e_kind    = tst_pkg::K_UNSUBACK;
                            w_row_we    = 1'b1;
                            w_row_wdata = {r_next, r_mask & ~w_bit_s};
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_s     = '0;
                        n_state = S_DRD;
                    end
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = S_SRD;
                end
            end
            // Walk the valid slots and deliver to each
            S_DRD: begin
                if (r_s == SCW'(SLOTS)) begin
                    n_state = S_IDLE;
                end else if (!r_mask[r_s[SIW-1:0]]) begin
                    n_s = r_s + 1'b1;
                end else begin
                    w_cli_re = 1'b1;
                    n_state  = S_DEMIT;
                end
            end
            S_DEMIT: begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    w_e_kind = tst_pkg::K_DELIVER;
                    w_e_dest = r_cli_q;
                    w_e_last = w_final;
                    n_s      = r_s + 1'b1;
                    n_state  = w_final ? S_IDLE : S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req;
        end
        r_t    <= n_t;
        r_base <= n_base;
        r_s    <= n_s;
        r_mask <= n_mask;
        r_next <= n_next;
        if (w_emit) begin
            r_out_kind <= w_e_kind;
            r_out_dest <= w_e_dest;
            r_out_last <= w_e_last;
        end
    end

    // Key and row memories, one port each, registered read
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            m_key[r_t[TIW-1:0]] <= {r_req.hi, r_req.lo};
        end
        if (w_key_re) begin
            r_key_q <= m_key[r_t[TIW-1:0]];
        end
        if (w_row_we) begin
            m_row[r_t[TIW-1:0]] <= w_row_wdata;
        end
        if (w_row_re) begin
            r_row_q <= m_row[r_t[TIW-1:0]];
        end
    end

    // Slot client memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_cli_we) begin
            m_cli[w_wr_sum[AW-1:0]] <= r_req.client;
        end
        if (w_cli_re) begin
            r_cli_q <= m_cli[w_rd_sum[AW-1:0]];
        end
    end

    assign o_m_valid  = r_out_vld;
    assign o_m_kind   = r_out_kind;
    assign o_m_dest   = r_out_dest;
    assign o_m_last   = r_out_last;
    assign o_used_cnt = tst_pkg::USED_W'(r_used);

endmodule

`default_nettype wire

// ===== rtl/topic_subscription_table_top.sv =====
// Top level of the topic subscription table: front end, queue, table engine.
// Depends on tst_pkg, tst_front, tst_queue and tst_back.
`timescale 1ns / 1ps
`default_nettype none

// Publish/subscribe routing table for up to TOPICS 128-bit topic keys with SLOTS
// subscriber slots each. Requests are checked in by a front register and a two-entry
// queue, so up to three requests can wait while the engine works or the output stalls.
// The engine handles one request at a time: the topic search reads the stored keys one
// by one from the key memory, comparing each, until it finds the topic or reaches the
// number of topics in use and decides that it is missing. Subscribe then writes the
// slot and topic row and answers. Unsubscribe uses the valid mask of the topic row to
// read and compare each valid slot through the client memory port, skipping each freed
// slot, and answers not found if no slot matches. Publish does the same sender check
// and then walks the slots again, one delivery per valid slot, skipping freed slots.
// A stalled output holds the engine wherever it has a result to give. Freed slots are not
// reused, and the table needs no clearing pass after reset.
module topic_subscription_table_top #(
    parameter int TOPICS = tst_pkg::TOPICS_DEF,
    parameter int SLOTS  = tst_pkg::SLOTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // topic_hi [63:0], topic_lo [127:64], client [137:128], zero pad above
    input  wire  [tst_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // cmd [1:0]
    input  wire  [tst_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // dest [9:0], zero pad above
    output logic [tst_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // kind [2:0]
    output logic [tst_pkg::KIND_W-1:0]        o_m_tuser,
    output logic                              o_m_tlast
);

    logic                        w_f_valid;
    logic                        w_f_ready;
    tst_pkg::t_req               w_f_req;
    logic                        w_q_valid;
    logic                        w_q_ready;
    tst_pkg::t_req               w_q_req;
    logic [tst_pkg::CLIENT_W-1:0] w_dest;
    logic [tst_pkg::USED_W-1:0]  w_used;

    tst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_req_valid (w_f_valid),
        .i_req_ready (w_f_ready),
        .o_req       (w_f_req)
    );

    tst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_data  (w_f_req),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_data  (w_q_req)
    );

    tst_back #(
        .TOPICS (TOPICS),
        .SLOTS  (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_q_valid),
        .o_req_ready (w_q_ready),
        .i_req       (w_q_req),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_m_kind    (o_m_tuser),
        .o_m_dest    (w_dest),
        .o_m_last    (o_m_tlast),
        .o_used_cnt  (w_used)
    );

    assign o_m_tdata = {(tst_pkg::OUT_DATA_W - tst_pkg::CLIENT_W)'(0), w_dest};

    // Every result other than a delivery closes its request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != tst_pkg::K_DELIVER)) |-> o_m_tlast)
        else $error("non-delivery result without last");

    // Topic count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= tst_pkg::USED_W'(TOPICS))
        else $error("topic count beyond table size");

    // Topic count only grows, one topic at a time
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used == $past(w_used)) || (w_used == $past(w_used) + 1'b1))
        else $error("topic count changed by other than one");

    // Result kinds stay within the defined codes
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= tst_pkg::K_NOT_FOUND))
        else $error("undefined result kind");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the topic subscription table top level.
// Depends on tst_pkg and topic_subscription_table_top; checks every reply
// against an in-bench routing table model.
`timescale 1ns / 1ps

module tb_top;

    localparam int NTOPICS      = tst_pkg::TOPICS_DEF;
    localparam int NSLOTS       = tst_pkg::SLOTS_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 95;

    localparam logic [tst_pkg::KEY_W-1:0]    KEY_ONES = '1;
    localparam logic [tst_pkg::KEY_W-1:0]    KEY_ZERO = '0;
    localparam logic [tst_pkg::CLIENT_W-1:0] CL_MAX   = '1;
    localparam logic [tst_pkg::CLIENT_W-1:0] CL_ZERO  = '0;

    typedef struct packed {
        logic [tst_pkg::KIND_W-1:0]   kind;
        logic [tst_pkg::CLIENT_W-1:0] dest;
        logic                         last;
    } t_reply;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tst_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [tst_pkg::CMD_W-1:0]      s_tuser  = tst_pkg::CMD_NOP;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tst_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [tst_pkg::KIND_W-1:0]     m_tuser;
    logic                           m_tlast;

    // Routing table as the bench sees it
    logic [tst_pkg::KEY_W-1:0]    topic_key_hi [NTOPICS];
    logic [tst_pkg::KEY_W-1:0]    topic_key_lo [NTOPICS];
    logic                         slot_live    [NTOPICS][NSLOTS];
    logic [tst_pkg::CLIENT_W-1:0] slot_owner   [NTOPICS][NSLOTS];
    int                           slot_fill    [NTOPICS];
    int                           topics_alloc = 0;

    t_reply expected_replies [$];
    int     error_count     = 0;
    int     quiet_cycles    = 0;
    int     feed_idle_pct   = 30;
    int     drain_stall_pct = 30;

    topic_subscription_table_top #(
        .TOPICS(NTOPICS),
        .SLOTS (NSLOTS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random client identifier
    function automatic logic [tst_pkg::CLIENT_W-1:0] rand_client();
        return tst_pkg::CLIENT_W'($urandom_range(0, 1023));
    endfunction

    function automatic bit key_hit(int t, logic [tst_pkg::KEY_W-1:0] hi,
                                   logic [tst_pkg::KEY_W-1:0] lo);
        return t < topics_alloc && topic_key_hi[t] == hi && topic_key_lo[t] == lo;
    endfunction

    // First live slot of topic t owned by client c, or -1
    function automatic int owner_slot(int t, logic [tst_pkg::CLIENT_W-1:0] c);
        int s;
        int found;
        found = -1;
        for (s = 0; s < NSLOTS; s++)
            if (found < 0 && slot_live[t][s] && slot_owner[t][s] == c)
                found = s;
        return found;
    endfunction

    function automatic void queue_reply(logic [tst_pkg::KIND_W-1:0] kind,
                                        logic [tst_pkg::CLIENT_W-1:0] dest,
                                        logic last);
        t_reply r;
        r.kind = kind;
        r.dest = dest;
        r.last = last;
        expected_replies.push_back(r);
    endfunction

    // Apply one accepted request to the table and queue the replies it causes
    function automatic void route_request(logic [tst_pkg::CMD_W-1:0] cmd,
                                          logic [tst_pkg::KEY_W-1:0] hi,
                                          logic [tst_pkg::KEY_W-1:0] lo,
                                          logic [tst_pkg::CLIENT_W-1:0] c);
        int t;
        int s;
        int hit;
        int final_s;
        hit = -1;
        case (cmd)
            tst_pkg::CMD_SUB: begin
                for (t = 0; t < NTOPICS; t++)
                    if (hit < 0 && key_hit(t, hi, lo))
                        hit = t;
                if (hit >= 0) begin
                    if (slot_fill[hit] >= NSLOTS) begin
                        queue_reply(tst_pkg::K_SLOTS_FULL, c, 1'b1);
                    end else begin
                        slot_live[hit][slot_fill[hit]]  = 1'b1;
                        slot_owner[hit][slot_fill[hit]] = c;
                        slot_fill[hit]++;
                        queue_reply(tst_pkg::K_SUBACK, c, 1'b1);
                    end
                end else if (topics_alloc >= NTOPICS) begin
                    queue_reply(tst_pkg::K_TOPICS_FULL, c, 1'b1);
                end else begin
                    t = topics_alloc;
                    topics_alloc++;
                    topic_key_hi[t]  = hi;
                    topic_key_lo[t]  = lo;
                    slot_live[t][0]  = 1'b1;
                    slot_owner[t][0] = c;
                    slot_fill[t]     = 1;
                    queue_reply(tst_pkg::K_SUBACK, c, 1'b1);
                end
            end
            tst_pkg::CMD_UNSUB: begin
                for (t = 0; t < NTOPICS; t++)
                    if (hit < 0 && key_hit(t, hi, lo) && owner_slot(t, c) >= 0)
                        hit = t;
                if (hit >= 0) begin
                    slot_live[hit][owner_slot(hit, c)] = 1'b0;
                    queue_reply(tst_pkg::K_UNSUBACK, c, 1'b1);
                end else begin
                    queue_reply(tst_pkg::K_NOT_FOUND, c, 1'b1);
                end
            end
            tst_pkg::CMD_PUB: begin
                for (t = 0; t < NTOPICS; t++)
                    if (hit < 0 && key_hit(t, hi, lo) && owner_slot(t, c) >= 0)
                        hit = t;
                if (hit >= 0) begin
                    final_s = 0;
                    for (s = 0; s < NSLOTS; s++)
                        if (slot_live[hit][s])
                            final_s = s;
                    for (s = 0; s < NSLOTS; s++)
                        if (slot_live[hit][s])
                            queue_reply(tst_pkg::K_DELIVER, slot_owner[hit][s],
                                        s == final_s);
                end else begin
                    queue_reply(tst_pkg::K_NOT_FOUND, c, 1'b1);
                end
            end
            default: begin
                // no-op command: no reply, no change
            end
        endcase
    endfunction

    // Present one request, hold it until taken, then predict its replies
    task automatic send_item(input logic [tst_pkg::CMD_W-1:0] cmd,
                             input logic [tst_pkg::KEY_W-1:0] hi,
                             input logic [tst_pkg::KEY_W-1:0] lo,
                             input logic [tst_pkg::CLIENT_W-1:0] c);
        int gap;
        gap = ($urandom_range(0, 99) < feed_idle_pct) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {{(tst_pkg::IN_DATA_W - tst_pkg::CLIENT_W - 2 * tst_pkg::KEY_W){1'b0}},
                    c, lo, hi};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        route_request(cmd, hi, lo, c);
    endtask

    // Empty table: nothing matches, not even the all-zero key
    task automatic test_empty_table();
        send_item(tst_pkg::CMD_PUB, KEY_ZERO, KEY_ZERO, CL_ZERO);
        send_item(tst_pkg::CMD_UNSUB, KEY_ZERO, KEY_ZERO, CL_ZERO);
        send_item(tst_pkg::CMD_NOP, KEY_ONES, KEY_ONES, CL_MAX);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ONES, CL_MAX);
    endtask

    // Subscribe, duplicate subscriptions, partial key, publish and unsubscribe
    task automatic test_subscribe_publish();
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, CL_MAX);
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, CL_ZERO);
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, CL_ZERO);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ZERO, CL_MAX);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ONES, 10'd5);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ONES, CL_ZERO);
        send_item(tst_pkg::CMD_UNSUB, KEY_ONES, KEY_ONES, CL_ZERO);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ONES, CL_ZERO);
        send_item(tst_pkg::CMD_UNSUB, KEY_ONES, KEY_ONES, 10'd5);
        send_item(tst_pkg::CMD_SUB, KEY_ZERO, KEY_ZERO, CL_ZERO);
        send_item(tst_pkg::CMD_PUB, KEY_ZERO, KEY_ZERO, CL_ZERO);
    endtask

    // Fill the slots of one topic; a freed slot must not come back
    task automatic test_slots_full();
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, 10'd512);
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, 10'd1);
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, 10'd2);
        send_item(tst_pkg::CMD_UNSUB, KEY_ONES, KEY_ONES, CL_MAX);
        send_item(tst_pkg::CMD_SUB, KEY_ONES, KEY_ONES, 10'd2);
        send_item(tst_pkg::CMD_PUB, KEY_ONES, KEY_ONES, CL_ZERO);
    endtask

    // Random traffic over a small key and client pool, steered toward real subscribers
    task automatic test_random_traffic();
        logic [tst_pkg::KEY_W-1:0]    pool_hi [12];
        logic [tst_pkg::KEY_W-1:0]    pool_lo [12];
        logic [tst_pkg::CLIENT_W-1:0] crowd   [8];
        logic [tst_pkg::KEY_W-1:0]    hi;
        logic [tst_pkg::KEY_W-1:0]    lo;
        logic [tst_pkg::CLIENT_W-1:0] c;
        logic [tst_pkg::CMD_W-1:0]    cmd;
        int                           sent;
        int                           r;
        int                           t;
        int                           s0;
        int                           k;
        int                           pick;
        for (k = 0; k < 12; k++) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        pool_hi[0] = KEY_ZERO;
        pool_lo[0] = KEY_ZERO;
        pool_hi[1] = KEY_ONES;
        pool_lo[1] = KEY_ONES;
        pool_lo[2] = pool_lo[3];
        for (k = 0; k < 8; k++)
            crowd[k] = rand_client();
        crowd[0] = CL_ZERO;
        crowd[1] = CL_MAX;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // run phases without idling, with heavy idling and with light idling
            if (sent < 30) begin
                feed_idle_pct   = 0;
                drain_stall_pct = 0;
            end else if (sent < 70) begin
                feed_idle_pct   = 50;
                drain_stall_pct = 40;
            end else begin
                feed_idle_pct   = 15;
                drain_stall_pct = 15;
            end
            r = $urandom_range(0, 99);
            cmd = (r < 40) ? tst_pkg::CMD_SUB :
                  (r < 60) ? tst_pkg::CMD_UNSUB :
                  (r < 95) ? tst_pkg::CMD_PUB : tst_pkg::CMD_NOP;
            k = $urandom_range(0, 11);
            hi = pool_hi[k];
            lo = pool_lo[k];
            c = crowd[$urandom_range(0, 7)];
            if ($urandom_range(0, 99) < 10) begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            if ($urandom_range(0, 99) < 15)
                c = rand_client();
            // steer most unsubscribes and publishes to a live subscription
            if ((cmd == tst_pkg::CMD_PUB || cmd == tst_pkg::CMD_UNSUB) && topics_alloc > 0 &&
                $urandom_range(0, 99) < 60) begin
                t = $urandom_range(0, topics_alloc - 1);
                s0 = $urandom_range(0, NSLOTS - 1);
                pick = -1;
                for (k = 0; k < NSLOTS; k++)
                    if (pick < 0 && slot_live[t][(s0 + k) % NSLOTS])
                        pick = (s0 + k) % NSLOTS;
                if (pick >= 0) begin
                    hi = topic_key_hi[t];
                    lo = topic_key_lo[t];
                    c  = slot_owner[t][pick];
                end
            end
            send_item(cmd, hi, lo, c);
            if (cmd != tst_pkg::CMD_NOP)
                sent++;
        end
    endtask

    // Use up the remaining topics, then ask for one more
    task automatic test_table_full();
        feed_idle_pct   = 30;
        drain_stall_pct = 30;
        while (topics_alloc < NTOPICS)
            send_item(tst_pkg::CMD_SUB, {$urandom, $urandom}, {$urandom, $urandom},
                      rand_client());
        send_item(tst_pkg::CMD_SUB, {$urandom, $urandom}, {$urandom, $urandom}, CL_MAX);
        send_item(tst_pkg::CMD_SUB, topic_key_hi[NTOPICS-1], topic_key_lo[NTOPICS-1],
                  CL_ZERO);
        send_item(tst_pkg::CMD_PUB, topic_key_hi[NTOPICS-1], topic_key_lo[NTOPICS-1],
                  CL_ZERO);
    endtask

    // Stall the result side at random
    initial begin : drive_ready
        int hold;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < drain_stall_pct)
                    hold = pick_gap();
            end
        end
    end

    // Compare each taken reply with the oldest prediction
    always @(posedge clk) begin : check_replies
        t_reply want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: kind %0d dest %0d last %0d",
                       m_tuser, m_tdata[tst_pkg::CLIENT_W-1:0], m_tlast);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[tst_pkg::CLIENT_W-1:0] !== want.dest) begin
                    $error("dest: expected %0d, actual %0d", want.dest,
                           m_tdata[tst_pkg::CLIENT_W-1:0]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // End the run when neither side moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : run_tests
        int t;
        int s;
        for (t = 0; t < NTOPICS; t++) begin
            topic_key_hi[t] = '0;
            topic_key_lo[t] = '0;
            slot_fill[t]    = 0;
            for (s = 0; s < NSLOTS; s++) begin
                slot_live[t][s]  = 1'b0;
                slot_owner[t][s] = '0;
            end
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_subscribe_publish();
        test_slots_full();
        test_random_traffic();
        test_table_full();

        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tst_pkg.sv
rtl/tst_front.sv
rtl/tst_queue.sv
rtl/tst_back.sv
rtl/topic_subscription_table_top.sv
test/tb_top.sv
